FILE: hdl/p3si_pkg.sv
// ----------------------------------------------------------------------------
// p3si_pkg
// Shared types and constants for the 3-D padding source index generator.
// ----------------------------------------------------------------------------
package p3si_pkg;

    // Axis mapping mode
    typedef enum logic [1:0] {
        MODE_CONSTANT  = 2'd0,
        MODE_REFLECT   = 2'd1,
        MODE_REPLICATE = 2'd2,
        MODE_CIRCULAR  = 2'd3
    } pad_mode_t;

    // Configuration register indexes
    localparam logic [2:0] REG_PAD_MODE      = 3'd0;
    localparam logic [2:0] REG_SOURCE_DEPTH  = 3'd1;
    localparam logic [2:0] REG_SOURCE_HEIGHT = 3'd2;
    localparam logic [2:0] REG_SOURCE_WIDTH  = 3'd3;
    localparam logic [2:0] REG_FRONT_PAD     = 3'd4;
    localparam logic [2:0] REG_TOP_PAD       = 3'd5;
    localparam logic [2:0] REG_LEFT_PAD      = 3'd6;
    localparam logic [2:0] REG_FILL_VALUE    = 3'd7;

    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 32;
    localparam int EXTENT_BITS    = 11;   // width of size and pad registers
    localparam int FIELD_BITS     = 12;   // width of one coordinate field
    localparam int INDEX_BITS     = 30;   // width of the source index
    localparam int WORD_BITS      = 32;   // width of the fill word
    localparam int IN_DATA_BITS   = 40;
    localparam int OUT_DATA_BITS  = 64;

endpackage

FILE: hdl/pad3d_source_index_core.sv
// ----------------------------------------------------------------------------
// pad3d_source_index_core
// Source address generator for 3-D tensor padding.
//
// Channel  Dir  Handshake        Payload
// s_axis   in   tvalid/tready    tdata: depth[11:0] row[23:12] col[35:24]
// m_axis   out  tvalid/tready    tdata: fill_word[31:0] source_index[61:32]
//                                tuser: use_fill
// cfg      in   cfg_we           cfg_index, cfg_data
//
// One request is taken per cycle while the output is not stalled. The pipe's
// depth grows with AW, the larger of the coordinate and extent widths (AW is
// 12 at default settings), via the one-bit-per-stage circular remainder pipe.
// Reset clears the valid bits and sets the configuration registers to their defaults.
// A stall at the output holds every stage; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module pad3d_source_index_core #(
    parameter int MAX_EXTENT = 1024,
    parameter int COORD_BITS = 12
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // depth[11:0], row[23:12], col[35:24], zero fill above
    input  logic [p3si_pkg::IN_DATA_BITS-1:0]    s_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // fill_word[31:0], source_index[61:32], zero fill above
    output logic [p3si_pkg::OUT_DATA_BITS-1:0]   m_tdata,
    // use_fill[0]
    output logic                                 m_tuser,
    input  logic                                 cfg_we,
    input  logic [p3si_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [p3si_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
    import p3si_pkg::*;

    localparam int EXT_BITS = $clog2(MAX_EXTENT + 1);
    localparam int CW       = (COORD_BITS < FIELD_BITS) ? COORD_BITS : FIELD_BITS;
    localparam int AW       = (CW > EXT_BITS) ? CW : EXT_BITS;
    localparam int LAT      = AW + 4;

    pad_mode_t              mode_reg;
    logic [EXTENT_BITS-1:0] depth_reg;
    logic [EXTENT_BITS-1:0] height_reg;
    logic [EXTENT_BITS-1:0] width_reg;
    logic [EXTENT_BITS-1:0] front_reg;
    logic [EXTENT_BITS-1:0] top_reg;
    logic [EXTENT_BITS-1:0] left_reg;
    logic [WORD_BITS-1:0]   fill_reg;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_CONSTANT;
            depth_reg  <= EXTENT_BITS'(1);
            height_reg <= EXTENT_BITS'(1);
            width_reg  <= EXTENT_BITS'(1);
            front_reg  <= '0;
            top_reg    <= '0;
            left_reg   <= '0;
            fill_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_PAD_MODE:      mode_reg   <= pad_mode_t'(cfg_data[1:0]);
                REG_SOURCE_DEPTH:  depth_reg  <= cfg_data[EXTENT_BITS-1:0];
                REG_SOURCE_HEIGHT: height_reg <= cfg_data[EXTENT_BITS-1:0];
                REG_SOURCE_WIDTH:  width_reg  <= cfg_data[EXTENT_BITS-1:0];
                REG_FRONT_PAD:     front_reg  <= cfg_data[EXTENT_BITS-1:0];
                REG_TOP_PAD:       top_reg    <= cfg_data[EXTENT_BITS-1:0];
                REG_LEFT_PAD:      left_reg   <= cfg_data[EXTENT_BITS-1:0];
                REG_FILL_VALUE:    fill_reg   <= cfg_data[WORD_BITS-1:0];
                default:           ;
            endcase
        end
    end

    // Saturate sizes and pads; a zero size acts as one
    logic [EXT_BITS-1:0] nd, nh, nw, pf, pt, pl;

    always_comb
    begin
        nd = (depth_reg == '0) ? EXT_BITS'(1) :
             (32'(depth_reg) > 32'(MAX_EXTENT)) ? EXT_BITS'(MAX_EXTENT) : EXT_BITS'(depth_reg);
        nh = (height_reg == '0) ? EXT_BITS'(1) :
             (32'(height_reg) > 32'(MAX_EXTENT)) ? EXT_BITS'(MAX_EXTENT) : EXT_BITS'(height_reg);
        nw = (width_reg == '0) ? EXT_BITS'(1) :
             (32'(width_reg) > 32'(MAX_EXTENT)) ? EXT_BITS'(MAX_EXTENT) : EXT_BITS'(width_reg);
        pf = (32'(front_reg) > 32'(MAX_EXTENT)) ? EXT_BITS'(MAX_EXTENT) : EXT_BITS'(front_reg);
        pt = (32'(top_reg) > 32'(MAX_EXTENT)) ? EXT_BITS'(MAX_EXTENT) : EXT_BITS'(top_reg);
        pl = (32'(left_reg) > 32'(MAX_EXTENT)) ? EXT_BITS'(MAX_EXTENT) : EXT_BITS'(left_reg);
    end

    // Plane size, registered off the configuration
    logic [2*EXT_BITS-1:0] plane_reg;

    always_ff @(posedge clk)
    begin
        plane_reg <= nh * nw;
    end

    // Valid bits travel with the stages; the whole pipe holds on a stall
    logic           adv;
    logic [LAT-1:0] vld_reg;
    logic [LAT-1:0] vld_next;

    assign adv      = !vld_reg[LAT-1] || m_tready;
    assign s_tready = adv;
    assign vld_next = {vld_reg[LAT-2:0], s_tvalid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= vld_next;
    end

    logic [EXT_BITS-1:0] md, mh, mw;
    logic                od, oh, ow;

    p3si_axis_map #(.CW(CW), .EXT_BITS(EXT_BITS), .AW(AW)) u_axis_d (
        .clk(clk), .en(adv), .mode(mode_reg), .coord(s_tdata[CW-1:0]),
        .pad(pf), .size(nd), .mapped(md), .outside(od)
    );

    p3si_axis_map #(.CW(CW), .EXT_BITS(EXT_BITS), .AW(AW)) u_axis_h (
        .clk(clk), .en(adv), .mode(mode_reg), .coord(s_tdata[FIELD_BITS+CW-1:FIELD_BITS]),
        .pad(pt), .size(nh), .mapped(mh), .outside(oh)
    );

    p3si_axis_map #(.CW(CW), .EXT_BITS(EXT_BITS), .AW(AW)) u_axis_w (
        .clk(clk), .en(adv), .mode(mode_reg),
        .coord(s_tdata[2*FIELD_BITS+CW-1:2*FIELD_BITS]),
        .pad(pl), .size(nw), .mapped(mw), .outside(ow)
    );

    logic [INDEX_BITS-1:0] index;
    logic                  use_fill;

    p3si_index_mac #(.EXT_BITS(EXT_BITS)) u_mac (
        .clk(clk), .en(adv), .d(md), .h(mh), .w(mw),
        .outside(od || oh || ow), .plane(plane_reg), .width(nw),
        .index(index), .fill(use_fill)
    );

    // Output packing
    assign m_tvalid = vld_reg[LAT-1];
    assign m_tuser  = use_fill;
    assign m_tdata  = {{(OUT_DATA_BITS-WORD_BITS-INDEX_BITS){1'b0}}, index, fill_reg};

    // Checks
    a_fill_zero_index: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata[WORD_BITS+INDEX_BITS-1:WORD_BITS] == '0)
        else $error("fill result carries a nonzero index");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(vld_reg))
        else $error("valid bits moved during a stall");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> vld_reg[0])
        else $error("accepted request missing from the first stage");

endmodule

FILE: hdl/p3si_axis_map.sv
// ----------------------------------------------------------------------------
// p3si_axis_map
// Maps one padded coordinate back into the source axis. One register stage
// removes the pad and resolves constant, reflect and replicate; AW
// compare-subtract stages reduce the offset for circular mode; one stage
// fixes the sign of the wrapped remainder.
// ----------------------------------------------------------------------------
module p3si_axis_map #(
    parameter int CW       = 12,
    parameter int EXT_BITS = 11,
    parameter int AW       = 12
) (
    input  logic                 clk,
    input  logic                 en,
    input  p3si_pkg::pad_mode_t  mode,
    input  logic [CW-1:0]        coord,
    input  logic [EXT_BITS-1:0]  pad,
    input  logic [EXT_BITS-1:0]  size,
    output logic [EXT_BITS-1:0]  mapped,
    output logic                 outside
);
    import p3si_pkg::*;

    localparam int RW = AW + 3;
    localparam int SW = AW + EXT_BITS;

    logic signed [RW-1:0] rel;
    logic signed [RW-1:0] n_s;
    logic signed [RW-1:0] abs_v;
    logic signed [RW-1:0] mirror;
    logic signed [RW-1:0] refl;
    logic signed [RW-1:0] pick;
    logic signed [RW-1:0] clamped;
    logic                 out_c;

    // Remove the pad and resolve the non-wrapping modes
    always_comb
    begin
        rel    = $signed({{(RW-CW){1'b0}}, coord}) - $signed({{(RW-EXT_BITS){1'b0}}, pad});
        n_s    = $signed({{(RW-EXT_BITS){1'b0}}, size});
        abs_v  = (rel < 0) ? -rel : rel;
        mirror = (n_s <<< 1) - abs_v - RW'(2);
        refl   = (mirror < abs_v) ? mirror : abs_v;
        out_c  = 1'b0;
        case (mode)
            MODE_REFLECT:   pick = refl;
            MODE_REPLICATE: pick = rel;
            MODE_CIRCULAR:  pick = '0;
            default:
            begin
                pick  = rel;
                out_c = (rel < 0) || (rel >= n_s);
            end
        endcase
        if (pick < 0)
            clamped = '0;
        else if (pick > n_s - RW'(1))
            clamped = n_s - RW'(1);
        else
            clamped = pick;
        if (out_c)
            clamped = '0;
    end

    logic [EXT_BITS-1:0] val_reg  [AW+1];
    logic                out_reg  [AW+1];
    logic                neg_reg  [AW+1];
    logic [AW-1:0]       rem_reg  [AW+1];

    // Entry stage
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            val_reg[0] <= clamped[EXT_BITS-1:0];
            out_reg[0] <= out_c;
            neg_reg[0] <= (rel < 0);
            rem_reg[0] <= abs_v[AW-1:0];
        end
    end

    // Restoring reduction, one divisor multiple per stage
    for (genvar i = 0; i < AW; i++)
    begin : g_step
        logic [SW-1:0] dv;
        logic [SW-1:0] rem_ext;
        logic [AW-1:0] rem_next;

        always_comb
        begin
            dv       = {{AW{1'b0}}, size} << (AW - 1 - i);
            rem_ext  = {{EXT_BITS{1'b0}}, rem_reg[i]};
            rem_next = (rem_ext >= dv) ? (rem_reg[i] - dv[AW-1:0]) : rem_reg[i];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                val_reg[i+1] <= val_reg[i];
                out_reg[i+1] <= out_reg[i];
                neg_reg[i+1] <= neg_reg[i];
                rem_reg[i+1] <= rem_next;
            end
        end
    end

    logic [EXT_BITS-1:0] r;
    logic [EXT_BITS-1:0] wrap;
    logic [EXT_BITS-1:0] mapped_reg;
    logic                outside_reg;

    // Fold negative offsets back from the top of the axis
    always_comb
    begin
        r    = rem_reg[AW][EXT_BITS-1:0];
        wrap = (neg_reg[AW] && (r != '0)) ? (size - r) : r;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mapped_reg  <= (mode == MODE_CIRCULAR) ? wrap : val_reg[AW];
            outside_reg <= out_reg[AW];
        end
    end

    assign mapped  = mapped_reg;
    assign outside = outside_reg;

endmodule

FILE: hdl/p3si_index_mac.sv
// ----------------------------------------------------------------------------
// p3si_index_mac
// Forms d*H*W + h*W + w in two register stages: products, then the sum.
// ----------------------------------------------------------------------------
module p3si_index_mac #(
    parameter int EXT_BITS = 11
) (
    input  logic                              clk,
    input  logic                              en,
    input  logic [EXT_BITS-1:0]               d,
    input  logic [EXT_BITS-1:0]               h,
    input  logic [EXT_BITS-1:0]               w,
    input  logic                              outside,
    input  logic [2*EXT_BITS-1:0]             plane,
    input  logic [EXT_BITS-1:0]               width,
    output logic [p3si_pkg::INDEX_BITS-1:0]   index,
    output logic                              fill
);
    import p3si_pkg::*;

    localparam int PW    = 3 * EXT_BITS;
    localparam int SUM_W = (PW + 2 > INDEX_BITS) ? PW + 2 : INDEX_BITS;

    logic [PW-1:0]         pd_reg;
    logic [2*EXT_BITS-1:0] ph_reg;
    logic [EXT_BITS-1:0]   pw_reg;
    logic                  po_reg;
    logic [SUM_W-1:0]      sum;
    logic [INDEX_BITS-1:0] index_reg;
    logic                  fill_reg;

    // Multiply stage
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pd_reg <= d * plane;
            ph_reg <= h * width;
            pw_reg <= w;
            po_reg <= outside;
        end
    end

    // Sum stage, zero the index where the fill value is taken
    always_comb
    begin
        sum = SUM_W'(pd_reg) + SUM_W'(ph_reg) + SUM_W'(pw_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            index_reg <= po_reg ? '0 : sum[INDEX_BITS-1:0];
            fill_reg  <= po_reg;
        end
    end

    assign index = index_reg;
    assign fill  = fill_reg;

endmodule
